// File: hw/rtl/tlca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlca_pkg;

   localparam int NODE_W     = 10;
   localparam int WEIGHT_W   = 32;
   localparam int DIST_W     = 42;
   localparam int COUNT_W    = 11;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_A_LO = 0;
   localparam int REQ_B_LO = REQ_A_LO + NODE_W;
   localparam int REQ_W_LO = REQ_B_LO + NODE_W;
   localparam int RSP_L_LO = NODE_W;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

   typedef enum logic [4:0] {
      STEP_IDLE      = 5'd0,
      STEP_DISP      = 5'd1,
      STEP_LD_CHK    = 5'd2,
      STEP_LD_START  = 5'd3,
      STEP_LD_CHAIN  = 5'd4,
      STEP_LD_NODE   = 5'd5,
      STEP_Q_RDA     = 5'd6,
      STEP_Q_RDB     = 5'd7,
      STEP_Q_ORDER   = 5'd8,
      STEP_Q_LIFT_RD = 5'd9,
      STEP_Q_LIFT    = 5'd10,
      STEP_Q_SAME    = 5'd11,
      STEP_Q_DESC_RD = 5'd12,
      STEP_Q_DESC    = 5'd13,
      STEP_Q_PAR_RD  = 5'd14,
      STEP_Q_PAR     = 5'd15,
      STEP_Q_DIST    = 5'd16,
      STEP_Q_SUB     = 5'd17,
      STEP_Q_BAD     = 5'd18,
      STEP_EMIT      = 5'd19
   } step_type;

   typedef enum logic [3:0] {
      COND_NEVER     = 4'd0,
      COND_ALWAYS    = 4'd1,
      COND_NO_ITEM   = 4'd2,
      COND_IS_QUERY  = 4'd3,
      COND_LOAD_BAD  = 4'd4,
      COND_QUERY_BAD = 4'd5,
      COND_ONE_LVL   = 4'd6,
      COND_LVL_END   = 4'd7,
      COND_LVL_ZERO  = 4'd8,
      COND_SAME      = 4'd9,
      COND_OUT_BUSY  = 4'd10
   } cond_type;

   typedef enum logic [2:0] {
      JA_NONE  = 3'd0,
      JA_B0    = 3'd1,
      JA_CHAIN = 3'd2,
      JA_A_LVL = 3'd3,
      JA_A0    = 3'd4
   } ja_type;

   typedef enum logic [1:0] {
      JW_NONE   = 2'd0,
      JW_PARENT = 2'd1,
      JW_CHAIN  = 2'd2
   } jw_type;

   typedef enum logic [1:0] {
      NR_NONE = 2'd0,
      NR_A    = 2'd1,
      NR_B    = 2'd2
   } nr_type;

   typedef enum logic [2:0] {
      RK_HOLD = 3'd0,
      RK_ONE  = 3'd1,
      RK_ZERO = 3'd2,
      RK_LAST = 3'd3,
      RK_INC  = 3'd4,
      RK_DEC  = 3'd5
   } rk_type;

   typedef enum logic [2:0] {
      AB_HOLD   = 3'd0,
      AB_ORDER  = 3'd1,
      AB_LIFT   = 3'd2,
      AB_DESC   = 3'd3,
      AB_PARENT = 3'd4,
      AB_BAD    = 3'd5
   } ab_type;

   typedef enum logic [2:0] {
      ACC_HOLD = 3'd0,
      ACC_LOAD = 3'd1,
      ACC_ADD  = 3'd2,
      ACC_SUB2 = 3'd3,
      ACC_CLR  = 3'd4
   } acc_type;

   typedef struct packed {
      step_type nxt;
      step_type jmp;
      cond_type cond;
      logic     accept;
      ja_type   ja;
      logic     jb;
      jw_type   jw;
      nr_type   nr;
      logic     nw;
      rk_type   rk;
      ab_type   ab;
      acc_type  acc;
      logic     dep_save;
      logic     emit;
   } uword_type;

   typedef struct packed {
      logic no_item;
      logic is_query;
      logic load_bad;
      logic query_bad;
      logic one_lvl;
      logic lvl_end;
      logic lvl_zero;
      logic same;
      logic out_busy;
   } cond_flags_type;

   localparam uword_type UWORD_NOP = '{
      nxt: STEP_IDLE, jmp: STEP_IDLE, cond: COND_NEVER, accept: 1'b0,
      ja: JA_NONE, jb: 1'b0, jw: JW_NONE, nr: NR_NONE, nw: 1'b0,
      rk: RK_HOLD, ab: AB_HOLD, acc: ACC_HOLD, dep_save: 1'b0, emit: 1'b0
   };

   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = UWORD_NOP;
      case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_ITEM;
            w.jmp    = STEP_IDLE;
            w.nxt    = STEP_DISP;
         end
         STEP_DISP: begin
            w.cond = COND_IS_QUERY;
            w.jmp  = STEP_Q_RDA;
            w.nxt  = STEP_LD_CHK;
         end
         STEP_LD_CHK: begin
            w.cond = COND_LOAD_BAD;
            w.jmp  = STEP_IDLE;
            w.nxt  = STEP_LD_START;
         end
         STEP_LD_START: begin
            w.jw   = JW_PARENT;
            w.ja   = JA_B0;
            w.nr   = NR_B;
            w.rk   = RK_ONE;
            w.cond = COND_ONE_LVL;
            w.jmp  = STEP_LD_NODE;
            w.nxt  = STEP_LD_CHAIN;
         end
         STEP_LD_CHAIN: begin
            w.jw   = JW_CHAIN;
            w.ja   = JA_CHAIN;
            w.rk   = RK_INC;
            w.cond = COND_LVL_END;
            w.jmp  = STEP_LD_NODE;
            w.nxt  = STEP_LD_CHAIN;
         end
         STEP_LD_NODE: begin
            w.nw   = 1'b1;
            w.cond = COND_ALWAYS;
            w.jmp  = STEP_IDLE;
         end
         STEP_Q_RDA: begin
            w.nr   = NR_A;
            w.cond = COND_QUERY_BAD;
            w.jmp  = STEP_Q_BAD;
            w.nxt  = STEP_Q_RDB;
         end
         STEP_Q_RDB: begin
            w.nr       = NR_B;
            w.acc      = ACC_LOAD;
            w.dep_save = 1'b1;
            w.nxt      = STEP_Q_ORDER;
         end
         STEP_Q_ORDER: begin
            w.acc = ACC_ADD;
            w.ab  = AB_ORDER;
            w.rk  = RK_ZERO;
            w.nxt = STEP_Q_LIFT_RD;
         end
         STEP_Q_LIFT_RD: begin
            w.ja  = JA_A_LVL;
            w.nxt = STEP_Q_LIFT;
         end
         STEP_Q_LIFT: begin
            w.ab   = AB_LIFT;
            w.rk   = RK_INC;
            w.cond = COND_LVL_END;
            w.jmp  = STEP_Q_SAME;
            w.nxt  = STEP_Q_LIFT_RD;
         end
         STEP_Q_SAME: begin
            w.rk   = RK_LAST;
            w.cond = COND_SAME;
            w.jmp  = STEP_Q_DIST;
            w.nxt  = STEP_Q_DESC_RD;
         end
         STEP_Q_DESC_RD: begin
            w.ja  = JA_A_LVL;
            w.jb  = 1'b1;
            w.nxt = STEP_Q_DESC;
         end
         STEP_Q_DESC: begin
            w.ab   = AB_DESC;
            w.rk   = RK_DEC;
            w.cond = COND_LVL_ZERO;
            w.jmp  = STEP_Q_PAR_RD;
            w.nxt  = STEP_Q_DESC_RD;
         end
         STEP_Q_PAR_RD: begin
            w.ja  = JA_A0;
            w.nxt = STEP_Q_PAR;
         end
         STEP_Q_PAR: begin
            w.ab  = AB_PARENT;
            w.nxt = STEP_Q_DIST;
         end
         STEP_Q_DIST: begin
            w.nr  = NR_A;
            w.nxt = STEP_Q_SUB;
         end
         STEP_Q_SUB: begin
            w.acc = ACC_SUB2;
            w.nxt = STEP_EMIT;
         end
         STEP_Q_BAD: begin
            w.ab   = AB_BAD;
            w.acc  = ACC_CLR;
            w.cond = COND_ALWAYS;
            w.jmp  = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_OUT_BUSY;
            w.jmp  = STEP_EMIT;
            w.nxt  = STEP_IDLE;
         end
         default: begin
            w = UWORD_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tree_lca_path_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                       Beat contents
// req      req_tvalid/tready/tdata/    tdata: node_a, node_b, edge_weight;
//          tuser                       tuser: op (0 load, 1 query)
// rsp      rsp_tvalid/tready/tdata/    tdata: ancestor, path_length;
//          tuser                       tuser: bad_index
// csr      csr_psel .. csr_pready      node_count at byte address 0
//
// A query skips the descent steps when one node is an ancestor of the other;
// a bad query clears the result and goes through its one bad step to emit.
// Reset clears the sequencer, the output register and node_count only; the
// tables need no clearing, since the root reads as zero and others are written
// before use. A result waits in the output register while the next beat is
// taken; the sequencer holds at its emit step only if that register is full.

module tree_lca_path_distance_top #(
   parameter int MAX_NODES   = 1024,
   parameter int JUMP_LEVELS = 10
) (
   input  wire                                clock,
   input  wire                                reset,

   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [9:0] node_a, [19:10] node_b, [51:20] edge_weight, [55:52] zero
   input  wire  [tlca_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] op
   input  wire                                req_tuser,

   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [9:0] ancestor, [51:10] path_length, [55:52] zero
   output logic [tlca_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] bad_index
   output logic                               rsp_tuser,

   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [tlca_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [tlca_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tlca_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int LVL_W = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
   localparam int DW    = (IDX_W > JUMP_LEVELS) ? IDX_W : JUMP_LEVELS;
   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(JUMP_LEVELS - 1);

   localparam int NODE_W   = tlca_pkg::NODE_W;
   localparam int WEIGHT_W = tlca_pkg::WEIGHT_W;
   localparam int DIST_W   = tlca_pkg::DIST_W;
   localparam int COUNT_W  = tlca_pkg::COUNT_W;

   tlca_pkg::uword_type      ctl;
   tlca_pkg::step_type       step;
   tlca_pkg::cond_flags_type flags;

   logic [NODE_W-1:0]   req_a;
   logic [NODE_W-1:0]   req_b;
   logic [WEIGHT_W-1:0] req_w;
   logic                accept;
   logic                a_in_range;
   logic                b_in_range;

   logic [IDX_W-1:0]       ra_ff, ra_in;
   logic [IDX_W-1:0]       rb_ff, rb_in;
   logic [IDX_W-1:0]       rdep_ff, rdep_in;
   logic [LVL_W-1:0]       rk_ff, rk_in;
   logic [JUMP_LEVELS-1:0] diff_ff, diff_in;
   logic [DIST_W-1:0]      acc_ff, acc_in;
   logic [WEIGHT_W-1:0]    rw_ff, rw_in;
   logic                   is_query_ff, is_query_in;
   logic                   load_bad_ff, load_bad_in;
   logic                   query_bad_ff, query_bad_in;
   logic                   bad_ff, bad_in;
   logic [COUNT_W-1:0]     node_count_ff, node_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_anc_ff;
   logic [DIST_W-1:0]   rsp_len_ff;
   logic                rsp_bad_ff;
   logic                out_busy;
   logic                emit_fire;

   logic                jw_en;
   logic [IDX_W-1:0]    jw_node;
   logic [LVL_W-1:0]    jw_lvl;
   logic [IDX_W-1:0]    jw_data;
   logic                ja_en;
   logic [IDX_W-1:0]    ja_node;
   logic [LVL_W-1:0]    ja_lvl;
   logic [IDX_W-1:0]    jrd_a;
   logic [IDX_W-1:0]    jrd_b;
   logic                nr_en;
   logic [IDX_W-1:0]    nr_node;
   logic [IDX_W-1:0]    drd;
   logic [DIST_W-1:0]   xrd;

   logic                depth_less;
   logic [DW-1:0]       dsub;
   logic                csr_write;

   assign req_a  = req_tdata[tlca_pkg::REQ_B_LO-1:tlca_pkg::REQ_A_LO];
   assign req_b  = req_tdata[tlca_pkg::REQ_W_LO-1:tlca_pkg::REQ_B_LO];
   assign req_w  = req_tdata[tlca_pkg::REQ_W_LO+WEIGHT_W-1:tlca_pkg::REQ_W_LO];

   assign req_tready = ctl.accept;
   assign accept     = req_tvalid && req_tready;

   assign a_in_range = ({1'b0, req_a} < node_count_ff) &&
                       ({22'd0, req_a} < 32'(MAX_NODES));
   assign b_in_range = ({1'b0, req_b} < node_count_ff) &&
                       ({22'd0, req_b} < 32'(MAX_NODES));

   assign out_busy  = rsp_valid_ff && !rsp_tready;
   assign emit_fire = ctl.emit && !out_busy;

   always_comb begin
      flags.no_item   = !req_tvalid;
      flags.is_query  = is_query_ff;
      flags.load_bad  = load_bad_ff;
      flags.query_bad = query_bad_ff;
      flags.one_lvl   = (JUMP_LEVELS == 1);
      flags.lvl_end   = (rk_ff == LAST_LVL);
      flags.lvl_zero  = (rk_ff == '0);
      flags.same      = (ra_ff == rb_ff);
      flags.out_busy  = out_busy;
   end

   tlca_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .word  (ctl),
      .step  (step)
   );

   always_comb begin
      jw_en   = 1'b0;
      jw_node = ra_ff;
      jw_lvl  = rk_ff;
      jw_data = jrd_a;
      case (ctl.jw)
         tlca_pkg::JW_PARENT: begin
            jw_en   = 1'b1;
            jw_lvl  = '0;
            jw_data = rb_ff;
         end
         tlca_pkg::JW_CHAIN: begin
            jw_en = 1'b1;
         end
         default: begin
            jw_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      ja_en   = 1'b1;
      ja_node = ra_ff;
      ja_lvl  = rk_ff;
      case (ctl.ja)
         tlca_pkg::JA_B0: begin
            ja_node = rb_ff;
            ja_lvl  = '0;
         end
         tlca_pkg::JA_CHAIN: begin
            ja_node = jrd_a;
         end
         tlca_pkg::JA_A_LVL: begin
            ja_node = ra_ff;
         end
         tlca_pkg::JA_A0: begin
            ja_lvl = '0;
         end
         default: begin
            ja_en = 1'b0;
         end
      endcase
   end

   tlca_jump_mem #(
      .IDX_W (IDX_W),
      .LVL_W (LVL_W)
   ) u_jump_mem (
      .clock     (clock),
      .wr_en     (jw_en),
      .wr_node   (jw_node),
      .wr_lvl    (jw_lvl),
      .wr_data   (jw_data),
      .rd_a_en   (ja_en),
      .rd_a_node (ja_node),
      .rd_a_lvl  (ja_lvl),
      .rd_a_data (jrd_a),
      .rd_b_en   (ctl.jb),
      .rd_b_node (rb_ff),
      .rd_b_lvl  (rk_ff),
      .rd_b_data (jrd_b)
   );

   always_comb begin
      case (ctl.nr)
         tlca_pkg::NR_A: begin
            nr_en   = 1'b1;
            nr_node = ra_ff;
         end
         tlca_pkg::NR_B: begin
            nr_en   = 1'b1;
            nr_node = rb_ff;
         end
         default: begin
            nr_en   = 1'b0;
            nr_node = ra_ff;
         end
      endcase
   end

   tlca_node_mem #(
      .IDX_W (IDX_W)
   ) u_node_mem (
      .clock    (clock),
      .wr_en    (ctl.nw),
      .wr_node  (ra_ff),
      .wr_depth (drd + IDX_W'(1)),
      .wr_dist  (xrd + DIST_W'(rw_ff)),
      .rd_en    (nr_en),
      .rd_node  (nr_node),
      .rd_depth (drd),
      .rd_dist  (xrd)
   );

   assign depth_less = (rdep_ff < drd);
   assign dsub = depth_less ? (DW'(drd) - DW'(rdep_ff)) : (DW'(rdep_ff) - DW'(drd));

   always_comb begin
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      diff_in      = diff_ff;
      bad_in       = bad_ff;
      rw_in        = rw_ff;
      is_query_in  = is_query_ff;
      load_bad_in  = load_bad_ff;
      query_bad_in = query_bad_ff;
      if (accept) begin
         ra_in        = IDX_W'(req_a);
         rb_in        = IDX_W'(req_b);
         rw_in        = req_w;
         bad_in       = 1'b0;
         is_query_in  = req_tuser;
         load_bad_in  = !a_in_range || (req_a == '0) || (req_b >= req_a);
         query_bad_in = !a_in_range || !b_in_range;
      end else begin
         case (ctl.ab)
            tlca_pkg::AB_ORDER: begin
               if (depth_less) begin
                  ra_in = rb_ff;
                  rb_in = ra_ff;
               end
               diff_in = dsub[JUMP_LEVELS-1:0];
            end
            tlca_pkg::AB_LIFT: begin
               if (diff_ff[0]) begin
                  ra_in = jrd_a;
               end
               diff_in = diff_ff >> 1;
            end
            tlca_pkg::AB_DESC: begin
               if (jrd_a != jrd_b) begin
                  ra_in = jrd_a;
                  rb_in = jrd_b;
               end
            end
            tlca_pkg::AB_PARENT: begin
               ra_in = jrd_a;
            end
            tlca_pkg::AB_BAD: begin
               ra_in  = '0;
               bad_in = 1'b1;
            end
            default: begin
               ra_in = ra_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (ctl.rk)
         tlca_pkg::RK_ONE:  rk_in = LVL_W'(1);
         tlca_pkg::RK_ZERO: rk_in = '0;
         tlca_pkg::RK_LAST: rk_in = LAST_LVL;
         tlca_pkg::RK_INC:  rk_in = rk_ff + LVL_W'(1);
         tlca_pkg::RK_DEC:  rk_in = rk_ff - LVL_W'(1);
         default:           rk_in = rk_ff;
      endcase
   end

   always_comb begin
      case (ctl.acc)
         tlca_pkg::ACC_LOAD: acc_in = xrd;
         tlca_pkg::ACC_ADD:  acc_in = acc_ff + xrd;
         tlca_pkg::ACC_SUB2: acc_in = acc_ff - {xrd[DIST_W-2:0], 1'b0};
         tlca_pkg::ACC_CLR:  acc_in = '0;
         default:            acc_in = acc_ff;
      endcase
      rdep_in = ctl.dep_save ? drd : rdep_ff;
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_write && !csr_paddr[2]) begin
         node_count_in = csr_pwdata[COUNT_W-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= tlca_pkg::NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      rdep_ff      <= rdep_in;
      rk_ff        <= rk_in;
      diff_ff      <= diff_in;
      acc_ff       <= acc_in;
      rw_ff        <= rw_in;
      is_query_ff  <= is_query_in;
      load_bad_ff  <= load_bad_in;
      query_bad_ff <= query_bad_in;
      bad_ff       <= bad_in;
      if (emit_fire) begin
         rsp_anc_ff <= NODE_W'(ra_ff);
         rsp_len_ff <= acc_ff;
         rsp_bad_ff <= bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tlca_pkg::RSP_DATA_W - tlca_pkg::RSP_L_LO - DIST_W){1'b0}},
                        rsp_len_ff, rsp_anc_ff};
   assign rsp_tuser  = rsp_bad_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? '0 :
                       {{(tlca_pkg::CSR_DATA_W - COUNT_W){1'b0}}, node_count_ff};

   a_bad_result_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_anc_ff == '0 && rsp_len_ff == '0))
      else $error("bad-index result carries a non-zero payload");

   a_accept_goes_to_dispatch : assert property (@(posedge clock) disable iff (reset)
      accept |=> (step == tlca_pkg::STEP_DISP))
      else $error("sequencer did not dispatch an accepted beat");

   a_root_row_never_written : assert property (@(posedge clock) disable iff (reset)
      (ctl.jw != tlca_pkg::JW_NONE) |-> (ra_ff != '0))
      else $error("write to the root ancestor row");

   a_chain_level_nonzero : assert property (@(posedge clock) disable iff (reset)
      (ctl.jw == tlca_pkg::JW_CHAIN) |-> (rk_ff != '0))
      else $error("ancestor chain write at level zero");

endmodule

`default_nettype wire

// File: hw/rtl/tlca_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module tlca_useq (
   input  wire                      clock,
   input  wire                      reset,
   input  wire tlca_pkg::cond_flags_type flags,
   output tlca_pkg::uword_type      word,
   output tlca_pkg::step_type       step
);

   tlca_pkg::step_type upc_ff;
   tlca_pkg::step_type upc_in;
   logic               taken;

   always_comb begin
      word = tlca_pkg::ucode(upc_ff);
      step = upc_ff;
   end

   always_comb begin
      case (word.cond)
         tlca_pkg::COND_NEVER:     taken = 1'b0;
         tlca_pkg::COND_ALWAYS:    taken = 1'b1;
         tlca_pkg::COND_NO_ITEM:   taken = flags.no_item;
         tlca_pkg::COND_IS_QUERY:  taken = flags.is_query;
         tlca_pkg::COND_LOAD_BAD:  taken = flags.load_bad;
         tlca_pkg::COND_QUERY_BAD: taken = flags.query_bad;
         tlca_pkg::COND_ONE_LVL:   taken = flags.one_lvl;
         tlca_pkg::COND_LVL_END:   taken = flags.lvl_end;
         tlca_pkg::COND_LVL_ZERO:  taken = flags.lvl_zero;
         tlca_pkg::COND_SAME:      taken = flags.same;
         tlca_pkg::COND_OUT_BUSY:  taken = flags.out_busy;
         default:                  taken = 1'b0;
      endcase
      upc_in = taken ? word.jmp : word.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= tlca_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tlca_jump_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tlca_jump_mem #(
   parameter int IDX_W = 10,
   parameter int LVL_W = 4
) (
   input  wire              clock,
   input  wire              wr_en,
   input  wire  [IDX_W-1:0] wr_node,
   input  wire  [LVL_W-1:0] wr_lvl,
   input  wire  [IDX_W-1:0] wr_data,
   input  wire              rd_a_en,
   input  wire  [IDX_W-1:0] rd_a_node,
   input  wire  [LVL_W-1:0] rd_a_lvl,
   output logic [IDX_W-1:0] rd_a_data,
   input  wire              rd_b_en,
   input  wire  [IDX_W-1:0] rd_b_node,
   input  wire  [LVL_W-1:0] rd_b_lvl,
   output logic [IDX_W-1:0] rd_b_data
);

   localparam int DEPTH = 2 ** (IDX_W + LVL_W);

   logic [IDX_W-1:0] mem [DEPTH];
   logic [IDX_W-1:0] q_a_ff;
   logic [IDX_W-1:0] q_b_ff;
   logic             root_a_ff;
   logic             root_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_node, wr_lvl}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         q_a_ff    <= mem[{rd_a_node, rd_a_lvl}];
         root_a_ff <= (rd_a_node == '0);
      end
      if (rd_b_en) begin
         q_b_ff    <= mem[{rd_b_node, rd_b_lvl}];
         root_b_ff <= (rd_b_node == '0);
      end
   end

   // The root row is never written and always reads as zero.
   assign rd_a_data = root_a_ff ? '0 : q_a_ff;
   assign rd_b_data = root_b_ff ? '0 : q_b_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tlca_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tlca_node_mem #(
   parameter int IDX_W = 10
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [IDX_W-1:0]             wr_node,
   input  wire  [IDX_W-1:0]             wr_depth,
   input  wire  [tlca_pkg::DIST_W-1:0]  wr_dist,
   input  wire                          rd_en,
   input  wire  [IDX_W-1:0]             rd_node,
   output logic [IDX_W-1:0]             rd_depth,
   output logic [tlca_pkg::DIST_W-1:0]  rd_dist
);

   localparam int DEPTH = 2 ** IDX_W;

   logic [IDX_W-1:0]            depth_mem [DEPTH];
   logic [tlca_pkg::DIST_W-1:0] dist_mem  [DEPTH];
   logic [IDX_W-1:0]            depth_q_ff;
   logic [tlca_pkg::DIST_W-1:0] dist_q_ff;
   logic                        root_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         depth_mem[wr_node] <= wr_depth;
         dist_mem[wr_node]  <= wr_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         depth_q_ff <= depth_mem[rd_node];
         dist_q_ff  <= dist_mem[rd_node];
         root_ff    <= (rd_node == '0);
      end
   end

   // The root has depth zero and distance zero without ever being written.
   assign rd_depth = root_ff ? '0 : depth_q_ff;
   assign rd_dist  = root_ff ? '0 : dist_q_ff;

endmodule

`default_nettype wire
